/* hdl/sli_pkg.sv */
`default_nettype none

package sli_pkg;

   localparam int CAPACITY = 32;
   localparam int KEY_W    = 10;
   localparam int TAG_W    = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic {
      FUNC_INSERT  = 1'b0,
      FUNC_READOUT = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_ENTRY    = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_ROT_ASC,
      OP_ROT_DESC
   } op_type;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } cell_ctl_type;

endpackage

`default_nettype wire

/* hdl/sorted_list_insert_readout.sv */
`default_nettype none
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser: func; tdata: key, tag, descending
// rsp       out  rsp_tvalid/rsp_tready  tuser: status; tdata: out_key, out_tag; tlast
//
// An insert shifts the cell chain and gives its result beat the next
// cycle. A readout of n records first latches the count and the order, then
// gives n beats, one per cycle while rsp_tready allows, as the chain rotates
// once per beat and ends back in sorted order; an empty readout gives one beat
// the next cycle. Reset clears the valid bits and the count. req_tready is low
// while a readout streams or while a result beat is held by rsp_tready.

module sorted_list_insert_readout
   import sli_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [9:0] key, [25:10] tag, [26] descending
   input  wire logic        req_tuser,   // [0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [9:0] out_key, [25:10] out_tag
   output logic [1:0]       rsp_tuser,   // [1:0] status
   output logic             rsp_tlast
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             desc_ff, desc_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic             rsp_last_ff, rsp_last_in;

   cell_ctl_type     ctl;
   entry_type        ent [CAPACITY];
   logic             ge [CAPACITY];
   logic [CAPACITY-1:0] vld_v, tail_hot;
   entry_type        tail_ent;
   entry_type        rd_ent;

   logic             out_free, req_fire, step, is_insert, full;
   logic [KEY_W-1:0] req_key;
   logic [TAG_W-1:0] req_tag;
   logic             req_desc;

   assign req_key   = req_tdata[KEY_W-1:0];
   assign req_tag   = req_tdata[KEY_W+TAG_W-1:KEY_W];
   assign req_desc  = req_tdata[KEY_W+TAG_W];
   assign is_insert = (func_type'(req_tuser) == FUNC_INSERT);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign step       = (state_ff == S_READ) && out_free;

   // cell chain
   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         entry_type lft, rgt;
         logic      lge;
         if (g == 0) begin : g_first
            assign lft = tail_ent;
            assign lge = 1'b0;
         end else begin : g_mid
            assign lft = ent[g-1];
            assign lge = ge[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign rgt = '0;
         end else begin : g_inner
            assign rgt = ent[g+1];
         end
         sli_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .left_ent  (lft),
            .left_ge   (lge),
            .right_ent (rgt),
            .head_ent  (ent[0]),
            .ent       (ent[g]),
            .ge        (ge[g])
         );
         assign vld_v[g] = ent[g].valid;
      end
   endgenerate

   // the tail is the last valid cell
   assign tail_hot = vld_v & ~{1'b0, vld_v[CAPACITY-1:1]};

   always_comb begin
      tail_ent = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (tail_hot[i]) begin
            tail_ent = tail_ent | ent[i];
         end
      end
   end

   assign rd_ent = desc_ff ? tail_ent : ent[0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && !is_insert && (count_ff != '0)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (step && (left_ff == CNT_W'(1))) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl.key = req_key;
      ctl.tag = req_tag;
      ctl.op  = OP_HOLD;
      count_in = count_ff;
      left_in  = left_ff;
      desc_in  = desc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (is_insert) begin
                  rsp_valid_in  = 1'b1;
                  rsp_key_in    = '0;
                  rsp_tag_in    = '0;
                  rsp_last_in   = 1'b1;
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     rsp_status_in = ST_INSERTED;
                     ctl.op        = OP_INSERT;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
                  rsp_key_in    = '0;
                  rsp_tag_in    = '0;
                  rsp_last_in   = 1'b1;
               end else begin
                  left_in = count_ff;
                  desc_in = req_desc;
               end
            end
         end
         S_READ: begin
            if (step) begin
               // emit the current end, then rotate it away
               ctl.op        = desc_ff ? OP_ROT_DESC : OP_ROT_ASC;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ENTRY;
               rsp_key_in    = rd_ent.key;
               rsp_tag_in    = rd_ent.tag;
               rsp_last_in   = (left_ff == CNT_W'(1));
               left_in       = left_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      desc_ff       <= desc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(32-KEY_W-TAG_W){1'b0}}, rsp_tag_ff, rsp_key_ff};

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(vld_v) == int'(count_ff))
      else $error("entry count disagrees with cell valid bits");

   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !req_tready)
      else $error("request taken during readout");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && is_insert && full)
         |=> (rsp_tvalid && (rsp_tuser == ST_FULL) && $stable(count_ff)))
      else $error("insert into full list not dropped");

endmodule

`default_nettype wire

/* hdl/sli_cell.sv */
`default_nettype none

module sli_cell
   import sli_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire entry_type    left_ent,   // lower neighbour; tail entry for the first cell
   input  wire logic         left_ge,
   input  wire entry_type    right_ent,  // upper neighbour; empty for the last cell
   input  wire entry_type    head_ent,
   output entry_type         ent,
   output logic              ge
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   // empty slots count as greater so a new record lands in the first free one
   assign ge = !valid_ff || (key_ff >= ctl.key);

   assign ent.valid = valid_ff;
   assign ent.key   = key_ff;
   assign ent.tag   = tag_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (left_ge) begin
               // shift up to open the slot
               valid_in = left_ent.valid;
               key_in   = left_ent.key;
               tag_in   = left_ent.tag;
            end else if (ge) begin
               valid_in = 1'b1;
               key_in   = ctl.key;
               tag_in   = ctl.tag;
            end
         end
         OP_ROT_ASC: begin
            if (valid_ff) begin
               if (right_ent.valid) begin
                  key_in = right_ent.key;
                  tag_in = right_ent.tag;
               end else begin
                  // wrap the head round to the tail
                  key_in = head_ent.key;
                  tag_in = head_ent.tag;
               end
            end
         end
         OP_ROT_DESC: begin
            if (valid_ff) begin
               key_in = left_ent.key;
               tag_in = left_ent.tag;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

`default_nettype wire
